/* design/elevator_stepper_controller_macros.svh */
// Assertion macros for the elevator stepper controller.
`ifndef ELEVATOR_STEPPER_CONTROLLER_MACROS_SVH
`define ELEVATOR_STEPPER_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
`define ESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESC_ASSERT(label, prop, msg)
`define ESC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/esc_pkg.sv */
// Shared types, constants and the coil table of the elevator stepper controller.
package esc_pkg;

  localparam int FloorCount = 4;
  localparam int FloorW     = 2;
  localparam int CfgIdxW    = 3;
  localparam int CntW       = 16;

  localparam logic [CfgIdxW-1:0] RegStepsPerFloor = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStepTicks     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDoorTicks     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDwellTicks    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDebounceTicks = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBlinkHalf     = 3'd5;

  typedef struct packed {
    logic [CntW-1:0] floor_steps;
    logic [CntW-1:0] step_ticks;
    logic [CntW-1:0] door_ticks;
    logic [CntW-1:0] dwell_ticks;
    logic [CntW-1:0] debounce_ticks;
    logic [CntW-1:0] blink_half_ticks;
  } esc_cfg_t;

  typedef struct packed {
    logic [3:0]        coil_pattern;
    logic [FloorW-1:0] shown_floor;
    logic              door_open_drive;
    logic              door_close_drive;
    logic              door_open_led;
    logic              door_closed_led;
    logic              alarm_led;
  } esc_result_t;

  function automatic logic [3:0] coil_of(input logic up, input logic [1:0] k);
    logic [1:0] idx;
    idx = up ? k : ~k;
    case (idx)
      2'd0:    coil_of = 4'h9;
      2'd1:    coil_of = 4'hC;
      2'd2:    coil_of = 4'h6;
      default: coil_of = 4'h3;
    endcase
  endfunction

endpackage

/* design/esc_cfg_regs.sv */
// Configuration register file of the elevator stepper controller.
module esc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [esc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [esc_pkg::CntW-1:0]       cfg_data_i,
  output esc_pkg::esc_cfg_t              cfg_o
);
  import esc_pkg::*;

  esc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStepsPerFloor: cfg_d.floor_steps      = cfg_data_i;
        RegStepTicks:     cfg_d.step_ticks       = cfg_data_i;
        RegDoorTicks:     cfg_d.door_ticks       = cfg_data_i;
        RegDwellTicks:    cfg_d.dwell_ticks      = cfg_data_i;
        RegDebounceTicks: cfg_d.debounce_ticks   = cfg_data_i;
        RegBlinkHalf:     cfg_d.blink_half_ticks = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_steps      <= 16'd200;
      cfg_q.step_ticks       <= 16'd5;
      cfg_q.door_ticks       <= 16'd1200;
      cfg_q.dwell_ticks      <= 16'd1000;
      cfg_q.debounce_ticks   <= 16'd20;
      cfg_q.blink_half_ticks <= 16'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/esc_fsm.sv */
// Per-tick controller state, next-state logic and result decode.
module esc_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_en_i,
  input  logic [3:0]                buttons_n_i,
  input  logic                      emergency_n_i,
  input  esc_pkg::esc_cfg_t         cfg_i,
  output esc_pkg::esc_result_t      result_o
);
  import esc_pkg::*;

  localparam logic [2:0] MIdle     = 3'd0;
  localparam logic [2:0] MDebounce = 3'd1;
  localparam logic [2:0] MMove     = 3'd2;
  localparam logic [2:0] MOpen     = 3'd3;
  localparam logic [2:0] MDwell    = 3'd4;
  localparam logic [2:0] MClose    = 3'd5;
  localparam logic [2:0] MRelease  = 3'd6;
  localparam logic [2:0] MEmerg    = 3'd7;

  logic [2:0]        mode_q, mode_d;
  logic [FloorW-1:0] now_q, now_d;
  logic [FloorW-1:0] shown_q, shown_d;
  logic [FloorW-1:0] target_q, target_d;
  logic              up_q, up_d;
  logic [1:0]        phase_q, phase_d;
  logic [CntW-1:0]   steps_q, steps_d;
  logic [CntW-1:0]   timer_q, timer_d;
  logic              blink_q, blink_d;
  logic              closed_q, closed_d;

  logic [CntW-1:0]   timer_inc;
  logic [CntW-1:0]   steps_inc;
  logic [CntW-1:0]   limit;
  logic              done;
  logic              found;
  logic [FloorW-1:0] pick;
  logic [FloorW-1:0] shown_nx;
  logic              emergency;

  assign emergency = !emergency_n_i;
  assign timer_inc = timer_q + 16'd1;
  assign steps_inc = steps_q + 16'd1;

  always_comb begin
    case (mode_q)
      MEmerg:    limit = cfg_i.blink_half_ticks;
      MDebounce: limit = cfg_i.debounce_ticks;
      MMove:     limit = cfg_i.step_ticks;
      MDwell:    limit = cfg_i.dwell_ticks;
      default:   limit = cfg_i.door_ticks;
    endcase
  end

  assign done     = timer_inc >= limit;
  assign shown_nx = up_q ? shown_q + 2'd1 : shown_q - 2'd1;

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int f = 0; f < FloorCount; f++) begin
      if (!found && !buttons_n_i[f]) begin
        found = 1'b1;
        pick  = FloorW'(f);
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    now_d    = now_q;
    shown_d  = shown_q;
    target_d = target_q;
    up_d     = up_q;
    phase_d  = phase_q;
    steps_d  = steps_q;
    timer_d  = timer_q;
    blink_d  = blink_q;
    closed_d = closed_q;
    if (emergency && mode_q != MEmerg) begin
      now_d   = (mode_q == MMove) ? shown_q : now_q;
      shown_d = now_d;
      mode_d  = MEmerg;
      blink_d = 1'b1;
      timer_d = '0;
    end else begin
      case (mode_q)
        MEmerg: begin
          if (!emergency) begin
            mode_d  = MIdle;
            blink_d = 1'b0;
            timer_d = '0;
          end else begin
            timer_d = done ? '0 : timer_inc;
            if (done) blink_d = !blink_q;
          end
        end
        MIdle: begin
          if (found) begin
            target_d = pick;
            timer_d  = '0;
            if (cfg_i.debounce_ticks == '0) begin
              if (pick == now_q) begin
                mode_d = MRelease;
              end else begin
                up_d    = pick > now_q;
                phase_d = '0;
                steps_d = '0;
                shown_d = now_q;
                mode_d  = MMove;
              end
            end else begin
              mode_d = MDebounce;
            end
          end
        end
        MDebounce: begin
          if (buttons_n_i[target_q]) begin
            mode_d  = MIdle;
            timer_d = '0;
          end else begin
            timer_d = done ? '0 : timer_inc;
            if (done) begin
              timer_d = '0;
              if (target_q == now_q) begin
                mode_d = MRelease;
              end else begin
                up_d    = target_q > now_q;
                phase_d = '0;
                steps_d = '0;
                shown_d = now_q;
                mode_d  = MMove;
              end
            end
          end
        end
        MMove: begin
          timer_d = done ? '0 : timer_inc;
          if (done) begin
            phase_d = phase_q + 2'd1;
            steps_d = steps_inc;
            if (steps_inc >= cfg_i.floor_steps) begin
              steps_d = '0;
              shown_d = shown_nx;
              if (shown_nx == target_q) begin
                now_d    = target_q;
                closed_d = 1'b0;
                mode_d   = MOpen;
              end
            end
          end
        end
        MOpen: begin
          timer_d = done ? '0 : timer_inc;
          if (done) begin
            if (cfg_i.dwell_ticks == '0) begin
              closed_d = 1'b1;
              mode_d   = MClose;
            end else begin
              mode_d = MDwell;
            end
          end
        end
        MDwell: begin
          timer_d = done ? '0 : timer_inc;
          if (done) begin
            closed_d = 1'b1;
            mode_d   = MClose;
          end
        end
        MClose: begin
          timer_d = done ? '0 : timer_inc;
          if (done) mode_d = MRelease;
        end
        MRelease: begin
          if (buttons_n_i[target_q]) begin
            mode_d  = MIdle;
            timer_d = '0;
          end
        end
        default: begin
          mode_d  = MIdle;
          timer_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    result_o.coil_pattern     = (mode_d == MMove) ? coil_of(up_d, phase_d) : 4'h0;
    result_o.shown_floor      = shown_d;
    result_o.door_open_drive  = mode_d == MOpen;
    result_o.door_close_drive = mode_d == MClose;
    result_o.door_open_led    = !closed_d;
    result_o.door_closed_led  = closed_d;
    result_o.alarm_led        = (mode_d == MEmerg) && blink_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MIdle;
      now_q    <= '0;
      shown_q  <= '0;
      target_q <= '0;
      up_q     <= 1'b0;
      phase_q  <= '0;
      steps_q  <= '0;
      timer_q  <= '0;
      blink_q  <= 1'b0;
      closed_q <= 1'b1;
    end else if (step_en_i) begin
      mode_q   <= mode_d;
      now_q    <= now_d;
      shown_q  <= shown_d;
      target_q <= target_d;
      up_q     <= up_d;
      phase_q  <= phase_d;
      steps_q  <= steps_d;
      timer_q  <= timer_d;
      blink_q  <= blink_d;
      closed_q <= closed_d;
    end
  end

endmodule

/* design/elevator_stepper_controller.sv */
// Top level of the elevator stepper controller: input stage, controller, result stage.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | floor_buttons_n_i, emergency_n_i
//   out     | output    | out_valid_o/out_stall_i | coil, floor, door drives, LEDs
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One tick transaction per cycle unless the result stalls; a tick passes the input
// register, then the result register. The input register feeds the controller,
// whose next state is decoded into the result register in the same cycle. Reset
// restores the register values and an idle, closed-door car. A stalled result holds
// the input register; one further transaction is still taken while the result waits.
module elevator_stepper_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [3:0]                  floor_buttons_n_i,
  input  logic                        emergency_n_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [3:0]                  coil_pattern_o,
  output logic [esc_pkg::FloorW-1:0]  shown_floor_o,
  output logic                        door_open_drive_o,
  output logic                        door_close_drive_o,
  output logic                        door_open_led_o,
  output logic                        door_closed_led_o,
  output logic                        alarm_led_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [esc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [esc_pkg::CntW-1:0]    cfg_data_i
);
  import esc_pkg::*;

  `include "elevator_stepper_controller_macros.svh"

  esc_cfg_t    cfg;
  esc_result_t result;
  esc_result_t res_q;

  logic       in_valid_q, in_valid_d;
  logic [3:0] buttons_q;
  logic       emerg_n_q;
  logic       out_valid_q, out_valid_d;
  logic       advance;
  logic       in_accept;
  logic       coil_on;
  logic       door_or_alarm;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);

  esc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  esc_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (advance),
    .buttons_n_i   (buttons_q),
    .emergency_n_i (emerg_n_q),
    .cfg_i         (cfg),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      buttons_q <= floor_buttons_n_i;
      emerg_n_q <= emergency_n_i;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign coil_pattern_o     = res_q.coil_pattern;
  assign shown_floor_o      = res_q.shown_floor;
  assign door_open_drive_o  = res_q.door_open_drive;
  assign door_close_drive_o = res_q.door_close_drive;
  assign door_open_led_o    = res_q.door_open_led;
  assign door_closed_led_o  = res_q.door_closed_led;
  assign alarm_led_o        = res_q.alarm_led;

  assign coil_on       = out_valid_o && (coil_pattern_o != 4'h0);
  assign door_or_alarm = door_open_drive_o || door_close_drive_o || alarm_led_o;

  `ESC_ASSERT(a_coil_excl, !coil_on || !door_or_alarm, "coil driven with door or alarm")
  `ESC_ASSERT(a_led_excl, !out_valid_o || (door_open_led_o != door_closed_led_o), "door LEDs")
  `ESC_ASSERT(a_drive_excl, !out_valid_o || !(door_open_drive_o && door_close_drive_o), "door")
  `ESC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")

endmodule
